// ===== design/buvl_pkg.sv =====
// Shared constants, request codes and types of the bounded unique value list.
package buvl_pkg;

    localparam int CAPACITY    = 16;
    localparam int VALUE_WIDTH = 16;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int REQ_W       = 3;
    localparam int POS_W       = 5;
    localparam int TOTAL_W     = 20;
    localparam int SQ_W        = 35;

    localparam logic [REQ_W-1:0] REQ_CLEAR      = 3'd0;
    localparam logic [REQ_W-1:0] REQ_INSERT     = 3'd1;
    localparam logic [REQ_W-1:0] REQ_REMOVE     = 3'd2;
    localparam logic [REQ_W-1:0] REQ_LOOKUP     = 3'd3;
    localparam logic [REQ_W-1:0] REQ_REMOVE_KTH = 3'd4;
    localparam logic [REQ_W-1:0] REQ_REMOVE_MAX = 3'd5;

    typedef struct packed {
        logic                          clear;
        logic                          vld;
        logic signed [VALUE_WIDTH-1:0] elem;
    } acc_ctl_t;

endpackage

// ===== design/buvl_accum.sv =====
// Aggregate unit that folds one stored entry per cycle into minimum, sum, squares and odd count.
module buvl_accum (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  buvl_pkg::acc_ctl_t                     acc,
    output logic signed [buvl_pkg::VALUE_WIDTH-1:0] smallest,
    output logic signed [buvl_pkg::TOTAL_W-1:0]     total,
    output logic        [buvl_pkg::SQ_W-1:0]        square_total,
    output logic        [buvl_pkg::CNT_W-1:0]       odd_count
);
    import buvl_pkg::*;

    logic signed [2*VALUE_WIDTH-1:0] prod;
    logic                            s1_vld_reg;
    logic signed [VALUE_WIDTH-1:0]   s1_elem_reg;
    logic        [2*VALUE_WIDTH-1:0] s1_sq_reg;
    logic                            first_reg;
    logic signed [VALUE_WIDTH-1:0]   min_reg;
    logic signed [TOTAL_W-1:0]       sum_reg;
    logic        [SQ_W-1:0]          sq_reg;
    logic        [CNT_W-1:0]         odd_reg;

    assign prod = acc.elem * acc.elem;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            first_reg  <= 1'b1;
            min_reg    <= '0;
            sum_reg    <= '0;
            sq_reg     <= '0;
            odd_reg    <= '0;
        end
        else if (acc.clear)
        begin
            s1_vld_reg <= 1'b0;
            first_reg  <= 1'b1;
            min_reg    <= '0;
            sum_reg    <= '0;
            sq_reg     <= '0;
            odd_reg    <= '0;
        end
        else
        begin
            s1_vld_reg <= acc.vld;
            if (s1_vld_reg)
            begin
                first_reg <= 1'b0;
                if (first_reg || (s1_elem_reg < min_reg))
                begin
                    min_reg <= s1_elem_reg;
                end
                sum_reg <= sum_reg + TOTAL_W'(s1_elem_reg);
                sq_reg  <= sq_reg + SQ_W'(s1_sq_reg);
                odd_reg <= odd_reg + CNT_W'(s1_elem_reg[0]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_elem_reg <= acc.elem;
        s1_sq_reg   <= $unsigned(prod);
    end

    assign smallest     = min_reg;
    assign total        = sum_reg;
    assign square_total = sq_reg;
    assign odd_count    = odd_reg;

endmodule

// ===== design/buvl_seq.sv =====
// Request sequencer with the entry memory, fill count and the shared compare unit.
module buvl_seq (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic        [buvl_pkg::REQ_W-1:0]       req_type,
    input  logic signed [buvl_pkg::VALUE_WIDTH-1:0] value,
    input  logic        [buvl_pkg::POS_W-1:0]       position,
    output logic                                   busy,
    output logic                                   done,
    output logic                                   success,
    output logic        [buvl_pkg::CNT_W-1:0]       fill_count,
    output buvl_pkg::acc_ctl_t                     acc
);
    import buvl_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_SEARCH  = 7'b0000010,
        ST_MAXS    = 7'b0000100,
        ST_MOVE_RD = 7'b0001000,
        ST_MOVE_WR = 7'b0010000,
        ST_SCAN    = 7'b0100000,
        ST_RESP    = 7'b1000000
    } state_t;

    state_t                        state_reg, state_next;
    logic [REQ_W-1:0]              req_reg, req_next;
    logic signed [VALUE_WIDTH-1:0] val_reg, val_next;
    logic [IDX_W-1:0]              slot_reg, slot_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic                          ok_reg, ok_next;
    logic [CNT_W-1:0]              iss_reg, iss_next;
    logic                          rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]              rd_idx_reg, rd_idx_next;
    logic signed [VALUE_WIDTH-1:0] best_reg, best_next;

    logic signed [VALUE_WIDTH-1:0] mem [CAPACITY];
    logic signed [VALUE_WIDTH-1:0] rd_data_reg;
    logic [IDX_W-1:0]              rd_addr;
    logic                          we;
    logic [IDX_W-1:0]              wa;
    logic signed [VALUE_WIDTH-1:0] wd;

    logic                          issue;
    logic                          sweep_done;
    logic signed [VALUE_WIDTH-1:0] cmp_b;
    logic                          cmp_eq;
    logic                          cmp_gt;
    logic [POS_W-1:0]              pos_m1;
    logic                          pos_ok;
    logic [CNT_W-1:0]              last_idx;

    assign issue      = iss_reg < count_reg;
    assign sweep_done = !issue && !rd_vld_reg;
    assign cmp_b      = (state_reg == ST_MAXS) ? best_reg : val_reg;
    assign cmp_eq     = rd_data_reg == cmp_b;
    assign cmp_gt     = rd_data_reg > cmp_b;
    assign pos_m1     = position - 1'b1;
    assign pos_ok     = (position != '0) &&
                        ((POS_W + CNT_W)'(position) <= (POS_W + CNT_W)'(count_reg));
    assign last_idx   = count_reg - 1'b1;

    always_comb
    begin
        state_next  = state_reg;
        req_next    = req_reg;
        val_next    = val_reg;
        slot_next   = slot_reg;
        count_next  = count_reg;
        ok_next     = ok_reg;
        iss_next    = iss_reg;
        rd_vld_next = rd_vld_reg;
        rd_idx_next = rd_idx_reg;
        best_next   = best_reg;
        rd_addr     = iss_reg[IDX_W-1:0];
        we          = 1'b0;
        wa          = count_reg[IDX_W-1:0];
        wd          = val_reg;
        acc.clear   = 1'b0;
        acc.vld     = 1'b0;
        acc.elem    = rd_data_reg;

        if ((state_reg == ST_SEARCH) || (state_reg == ST_MAXS) || (state_reg == ST_SCAN))
        begin
            rd_vld_next = issue;
            rd_idx_next = iss_reg[IDX_W-1:0];
            if (issue)
            begin
                iss_next = iss_reg + 1'b1;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next    = req_type;
                    val_next    = value;
                    ok_next     = 1'b0;
                    iss_next    = '0;
                    rd_vld_next = 1'b0;
                    state_next  = ST_SCAN;
                    acc.clear   = 1'b1;
                    case (req_type)
                        REQ_CLEAR:
                        begin
                            count_next = '0;
                            ok_next    = 1'b1;
                        end
                        REQ_INSERT:
                        begin
                            if (count_reg != CNT_W'(CAPACITY))
                            begin
                                state_next = ST_SEARCH;
                            end
                        end
                        REQ_REMOVE, REQ_LOOKUP:
                        begin
                            state_next = ST_SEARCH;
                        end
                        REQ_REMOVE_KTH:
                        begin
                            if (pos_ok)
                            begin
                                slot_next  = IDX_W'(pos_m1);
                                state_next = ST_MOVE_RD;
                            end
                        end
                        REQ_REMOVE_MAX:
                        begin
                            if (count_reg != '0)
                            begin
                                state_next = ST_MAXS;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SEARCH:
            begin
                if (rd_vld_reg && cmp_eq)
                begin
                    slot_next = rd_idx_reg;
                    if (req_reg == REQ_REMOVE)
                    begin
                        ok_next    = 1'b1;
                        state_next = ST_MOVE_RD;
                    end
                    else
                    begin
                        ok_next     = (req_reg == REQ_LOOKUP);
                        iss_next    = '0;
                        rd_vld_next = 1'b0;
                        acc.clear   = 1'b1;
                        state_next  = ST_SCAN;
                    end
                end
                else if (sweep_done)
                begin
                    if (req_reg == REQ_INSERT)
                    begin
                        we         = 1'b1;
                        count_next = count_reg + 1'b1;
                        ok_next    = 1'b1;
                    end
                    iss_next    = '0;
                    rd_vld_next = 1'b0;
                    acc.clear   = 1'b1;
                    state_next  = ST_SCAN;
                end
            end
            ST_MAXS:
            begin
                if (rd_vld_reg && ((rd_idx_reg == '0) || cmp_gt))
                begin
                    best_next = rd_data_reg;
                    slot_next = rd_idx_reg;
                end
                if (sweep_done)
                begin
                    state_next = ST_MOVE_RD;
                end
            end
            ST_MOVE_RD:
            begin
                rd_addr    = last_idx[IDX_W-1:0];
                state_next = ST_MOVE_WR;
            end
            ST_MOVE_WR:
            begin
                we          = 1'b1;
                wa          = slot_reg;
                wd          = rd_data_reg;
                count_next  = last_idx;
                ok_next     = 1'b1;
                iss_next    = '0;
                rd_vld_next = 1'b0;
                acc.clear   = 1'b1;
                state_next  = ST_SCAN;
            end
            ST_SCAN:
            begin
                acc.vld = rd_vld_reg;
                if (sweep_done)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            ok_reg     <= 1'b0;
            iss_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ok_reg     <= ok_next;
            iss_reg    <= iss_next;
            rd_vld_reg <= rd_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        val_reg    <= val_next;
        slot_reg   <= slot_next;
        rd_idx_reg <= rd_idx_next;
        best_reg   <= best_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign busy       = state_reg != ST_IDLE;
    assign done       = state_reg == ST_RESP;
    assign success    = ok_reg;
    assign fill_count = count_reg;

endmodule

// ===== design/bounded_unique_value_list.sv =====
// Top level of the bounded unique value list: sequencer, entry memory and aggregate unit.
//
// A request is a transfer of req_type, value and position, taken at a rising edge
// where start is high and busy is low. busy stays high until the request's result
// has been shown. The result appears on success, fill_count, smallest, total,
// square_total and odd_count for exactly one cycle while done is high; the
// receiver takes it in that cycle and cannot stall the block.
// A request runs, as it needs them, a search or maximum pass over the N stored
// entries (which a search can end early on a hit), a move of the last entry into
// a freed slot after a removal, and then the aggregate pass before the result is
// shown; the next request can be taken in the cycle after the result.
// Both passes go through the single read port of the entry memory, one entry
// per cycle, and the aggregate unit squares one entry per cycle.
// Reset empties the store and returns the block to idle; the entry memory itself
// is not cleared, since only slots below the fill count are ever read.
module bounded_unique_value_list (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic        [buvl_pkg::REQ_W-1:0]       req_type,
    input  logic signed [buvl_pkg::VALUE_WIDTH-1:0] value,
    input  logic        [buvl_pkg::POS_W-1:0]       position,
    output logic                                   busy,
    output logic                                   done,
    output logic                                   success,
    output logic        [buvl_pkg::CNT_W-1:0]       fill_count,
    output logic signed [buvl_pkg::VALUE_WIDTH-1:0] smallest,
    output logic signed [buvl_pkg::TOTAL_W-1:0]     total,
    output logic        [buvl_pkg::SQ_W-1:0]        square_total,
    output logic        [buvl_pkg::CNT_W-1:0]       odd_count
);
    import buvl_pkg::*;

    acc_ctl_t acc;

    buvl_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .req_type   (req_type),
        .value      (value),
        .position   (position),
        .busy       (busy),
        .done       (done),
        .success    (success),
        .fill_count (fill_count),
        .acc        (acc)
    );

    buvl_accum u_accum (
        .clk          (clk),
        .rst_n        (rst_n),
        .acc          (acc),
        .smallest     (smallest),
        .total        (total),
        .square_total (square_total),
        .odd_count    (odd_count)
    );

endmodule

// ===== bench/bounded_unique_value_list_tb.sv =====
// Self-checking testbench for the bounded unique value list with a scoreboard that predicts each result.
`timescale 1ns / 100ps

module bounded_unique_value_list_tb;
    import buvl_pkg::*;

    localparam logic [REQ_W-1:0] REQ_SPARE_LOW  = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE_HIGH = 3'd7;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS    = 345;

    typedef struct packed {
        logic                          success;
        logic        [CNT_W-1:0]       fill_count;
        logic signed [VALUE_WIDTH-1:0] smallest;
        logic signed [TOTAL_W-1:0]     total;
        logic        [SQ_W-1:0]        square_total;
        logic        [CNT_W-1:0]       odd_count;
    } list_summary_t;

    class list_scoreboard;
        logic signed [VALUE_WIDTH-1:0] slots[CAPACITY];
        int                            fill;
        list_summary_t                 pending_summaries[$];
        int                            errors;
        int                            per_req[8];
        int                            hits;
        int                            full_rejects;

        function void swap_out(int slot);
            slots[slot] = slots[fill - 1];
            fill--;
        endfunction

        function void note_request(logic [REQ_W-1:0] req, logic signed [VALUE_WIDTH-1:0] v,
                                   logic [POS_W-1:0] pos);
            list_summary_t                 s;
            int                            found;
            int                            best;
            longint                        squares;
            logic signed [VALUE_WIDTH-1:0] low;
            logic signed [TOTAL_W-1:0]     sum;
            int                            odd;
            s = '0;
            found = -1;
            for (int i = 0; i < fill; i++)
            begin
                if (found < 0 && slots[i] == v)
                    found = i;
            end
            per_req[req]++;
            case (req)
                REQ_CLEAR:
                begin
                    fill = 0;
                    s.success = 1'b1;
                end
                REQ_INSERT:
                begin
                    if (fill == CAPACITY)
                        full_rejects++;
                    if (fill < CAPACITY && found < 0)
                    begin
                        slots[fill] = v;
                        fill++;
                        s.success = 1'b1;
                    end
                end
                REQ_REMOVE:
                begin
                    if (found >= 0)
                    begin
                        swap_out(found);
                        s.success = 1'b1;
                    end
                end
                REQ_LOOKUP:
                    s.success = (found >= 0);
                REQ_REMOVE_KTH:
                begin
                    if (pos >= 1 && pos <= fill)
                    begin
                        swap_out(int'(pos) - 1);
                        s.success = 1'b1;
                    end
                end
                REQ_REMOVE_MAX:
                begin
                    if (fill > 0)
                    begin
                        best = 0;
                        for (int i = 1; i < fill; i++)
                        begin
                            if (slots[i] > slots[best])
                                best = i;
                        end
                        swap_out(best);
                        s.success = 1'b1;
                    end
                end
                default:
                    ;
            endcase
            low = '0;
            sum = '0;
            squares = 0;
            odd = 0;
            for (int i = 0; i < fill; i++)
            begin
                if (i == 0 || slots[i] < low)
                    low = slots[i];
                sum = sum + slots[i];
                squares += longint'(slots[i]) * longint'(slots[i]);
                if (slots[i][0])
                    odd++;
            end
            s.fill_count   = fill[CNT_W-1:0];
            s.smallest     = low;
            s.total        = sum;
            s.square_total = squares[SQ_W-1:0];
            s.odd_count    = odd[CNT_W-1:0];
            if (s.success)
                hits++;
            pending_summaries.push_back(s);
        endfunction

        function void report_field(string field, longint want, longint seen);
            errors++;
            if (errors <= 10)
                $display("Mismatch in %s: expected %0d, got %0d", field, want, seen);
        endfunction

        function void check_result(list_summary_t got);
            list_summary_t want;
            if (pending_summaries.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("Result transfer with no request outstanding");
                return;
            end
            want = pending_summaries.pop_front();
            if (got.success !== want.success)
                report_field("success", want.success, got.success);
            if (got.fill_count !== want.fill_count)
                report_field("fill_count", want.fill_count, got.fill_count);
            if (got.smallest !== want.smallest)
                report_field("smallest", want.smallest, got.smallest);
            if (got.total !== want.total)
                report_field("total", want.total, got.total);
            if (got.square_total !== want.square_total)
                report_field("square_total", want.square_total, got.square_total);
            if (got.odd_count !== want.odd_count)
                report_field("odd_count", want.odd_count, got.odd_count);
        endfunction
    endclass

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          start = 1'b0;
    logic        [REQ_W-1:0]       req_type = REQ_CLEAR;
    logic signed [VALUE_WIDTH-1:0] value = '0;
    logic        [POS_W-1:0]       position = '0;
    logic                          busy;
    logic                          done;
    logic                          success;
    logic        [CNT_W-1:0]       fill_count;
    logic signed [VALUE_WIDTH-1:0] smallest;
    logic signed [TOTAL_W-1:0]     total;
    logic        [SQ_W-1:0]        square_total;
    logic        [CNT_W-1:0]       odd_count;

    list_scoreboard board = new();
    int             issued;
    int             idle_pct;
    int             stall_cycles;

    bounded_unique_value_list i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .req_type     (req_type),
        .value        (value),
        .position     (position),
        .busy         (busy),
        .done         (done),
        .success      (success),
        .fill_count   (fill_count),
        .smallest     (smallest),
        .total        (total),
        .square_total (square_total),
        .odd_count    (odd_count)
    );

    initial
    begin
        forever
            #10 clk = ~clk;
    end

    always @(posedge clk)
    begin : result_monitor
        list_summary_t got;
        if (rst_n)
        begin
            if (done)
            begin
                got.success      = success;
                got.fill_count   = fill_count;
                got.smallest     = smallest;
                got.total        = total;
                got.square_total = square_total;
                got.odd_count    = odd_count;
                board.check_result(got);
            end
            if (start && !busy)
                board.note_request(req_type, value, position);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog expired after %0d cycles without a transfer", stall_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_request(input logic [REQ_W-1:0] req,
                                input logic signed [VALUE_WIDTH-1:0] v,
                                input logic [POS_W-1:0] pos);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 45))
                @(posedge clk);
        end
        start    <= 1'b1;
        req_type <= req;
        value    <= v;
        position <= pos;
        do
            @(posedge clk);
        while (busy);
        issued++;
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (board.pending_summaries.size() != 0);
    endtask

    function automatic logic signed [VALUE_WIDTH-1:0] pick_operand();
        int r;
        int t;
        r = $urandom_range(99);
        if (r < 40 && board.fill > 0)
            return board.slots[$urandom_range(board.fill - 1)];
        if (r < 75)
        begin
            t = int'($urandom_range(40)) - 20;
            return t[VALUE_WIDTH-1:0];
        end
        return VALUE_WIDTH'($urandom());
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        if ($urandom_range(99) < 70 && board.fill > 0)
            return POS_W'($urandom_range(1, board.fill));
        return POS_W'($urandom_range(0, CAPACITY));
    endfunction

    task automatic run_phase(input int items);
        int first;
        int r;
        first = issued;
        while (issued - first < items)
        begin
            r = $urandom_range(99);
            if (r < 8)
            begin
                repeat (CAPACITY + 2)
                    send_request(REQ_INSERT, pick_operand(), pick_position());
            end
            else if (r < 13)
            begin
                repeat ($urandom_range(1, 8))
                    send_request(REQ_REMOVE_MAX, pick_operand(), pick_position());
            end
            else if (r < 48)
                send_request(REQ_INSERT, pick_operand(), pick_position());
            else if (r < 61)
                send_request(REQ_REMOVE, pick_operand(), pick_position());
            else if (r < 74)
                send_request(REQ_LOOKUP, pick_operand(), pick_position());
            else if (r < 86)
                send_request(REQ_REMOVE_KTH, pick_operand(), pick_position());
            else if (r < 94)
                send_request(REQ_REMOVE_MAX, pick_operand(), pick_position());
            else if (r < 96)
                send_request(REQ_CLEAR, pick_operand(), pick_position());
            else if (r < 98)
                send_request(REQ_SPARE_LOW, pick_operand(), pick_position());
            else
                send_request(REQ_SPARE_HIGH, pick_operand(), pick_position());
        end
    endtask

    initial
    begin
        issued = 0;
        idle_pct = 0;
        rst_n <= 1'b0;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;

        send_request(REQ_CLEAR, 16'sd0, 5'd0);
        send_request(REQ_REMOVE_MAX, 16'sd0, 5'd0);
        send_request(REQ_REMOVE_KTH, 16'sd0, 5'd1);
        send_request(REQ_LOOKUP, 16'sd0, 5'd0);
        send_request(REQ_REMOVE, 16'sd0, 5'd0);
        send_request(REQ_INSERT, -16'sd32768, 5'd0);
        send_request(REQ_INSERT, 16'sd32767, 5'd31);
        send_request(REQ_INSERT, -16'sd32768, 5'd0);
        send_request(REQ_INSERT, 16'sd0, 5'd0);
        send_request(REQ_INSERT, -16'sd1, 5'd0);
        send_request(REQ_INSERT, 16'sd1, 5'd0);
        send_request(REQ_INSERT, -16'sd21846, 5'd0);
        send_request(REQ_INSERT, 16'sd21845, 5'd0);
        send_request(REQ_LOOKUP, 16'sd32767, 5'd0);
        send_request(REQ_LOOKUP, 16'sd2, 5'd0);
        send_request(REQ_REMOVE, 16'sd2, 5'd0);
        send_request(REQ_REMOVE_KTH, 16'sd0, 5'd0);
        send_request(REQ_REMOVE_KTH, 16'sd0, 5'd16);
        send_request(REQ_REMOVE_KTH, 16'sd0, 5'd15);
        send_request(REQ_REMOVE_KTH, 16'sd0, 5'd2);
        send_request(REQ_REMOVE_MAX, 16'sd0, 5'd0);
        send_request(REQ_SPARE_LOW, -16'sd1, 5'd16);
        send_request(REQ_SPARE_HIGH, 16'sd5, 5'd1);
        send_request(REQ_REMOVE, -16'sd1, 5'd0);
        send_request(REQ_CLEAR, 16'sd0, 5'd0);

        idle_pct = 15;
        run_phase(PHASE_ITEMS);
        wait_drained();
        idle_pct = 64;
        run_phase(PHASE_ITEMS);
        wait_drained();
        idle_pct = 0;
        run_phase(PHASE_ITEMS);
        wait_drained();
        repeat (60)
            @(posedge clk);

        $display("Covered %0d requests, %0d successful: clear %0d, insert %0d, remove %0d,",
                 issued, board.hits, board.per_req[REQ_CLEAR], board.per_req[REQ_INSERT],
                 board.per_req[REQ_REMOVE]);
        $display("lookup %0d, remove kth %0d, remove max %0d, unused codes %0d, full inserts %0d",
                 board.per_req[REQ_LOOKUP], board.per_req[REQ_REMOVE_KTH],
                 board.per_req[REQ_REMOVE_MAX],
                 board.per_req[REQ_SPARE_LOW] + board.per_req[REQ_SPARE_HIGH],
                 board.full_rejects);
        if (board.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
